>>> rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants, codes and packet types of the bounded packet fifo with
// duplicate filter and range count.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int DEPTH      = 64;
    localparam int NODE_WIDTH = 16;
    localparam int TIME_WIDTH = 32;

    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int LIMIT_W = 7;
    localparam int CNT_W   = 7;
    localparam int CMD_W   = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam int IN_BITS    = 2 * NODE_WIDTH + 3 * TIME_WIDTH;
    localparam int S_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 + 2 * NODE_WIDTH + TIME_WIDTH + CNT_W;
    localparam int M_DATA_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam int S_USER_W   = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_COUNT   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] ts;
        logic [NODE_WIDTH-1:0] dst;
        logic [NODE_WIDTH-1:0] src;
    } packet_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] end_time;
        logic [TIME_WIDTH-1:0] start_time;
        logic [TIME_WIDTH-1:0] timestamp;
        logic [NODE_WIDTH-1:0] destination;
        logic [NODE_WIDTH-1:0] source;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]      match_count;
        logic [TIME_WIDTH-1:0] out_timestamp;
        logic [NODE_WIDTH-1:0] out_destination;
        logic [NODE_WIDTH-1:0] out_source;
        logic                  forward_valid;
        logic                  added;
    } out_item_t;

endpackage

>>> rtl/packet_fifo_dedup_range_count.sv
// Steps: forward reads the oldest packet, if any, and emits; add scans the stored
// packets, commits and emits; count scans and emits; an unknown command only emits.
// Throughput: one item at a time; add and count scan the stored packets through
// the single read port of the packet store, one entry per cycle.
// Reset (aresetn low, synchronous) empties the fifo and sets the limit to 64;
// the store contents are not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count
// Bounded packet fifo with duplicate filter, eviction of the oldest packet at
// the configured limit, forward of the oldest packet and range count.
// ----------------------------------------------------------------------------
module packet_fifo_dedup_range_count (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pfd_pkg::LIMIT_W-1:0]     cfg_wr_data,   // fifo limit
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // source, destination, timestamp, start_time, end_time
    input  logic [pfd_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // command
    input  logic [pfd_pkg::S_USER_W-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // added, forward_valid, out_source, out_destination, out_timestamp,
    // match_count
    output logic [pfd_pkg::M_DATA_W-1:0]    m_axis_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FWD_DATA,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    state_t                         state_reg, state_next;
    logic [pfd_pkg::LIMIT_W-1:0]    limit_reg;
    logic [pfd_pkg::ADDR_W-1:0]     oldest_reg, oldest_next;
    logic [pfd_pkg::OCC_W-1:0]      occ_reg, occ_next;
    logic [pfd_pkg::OCC_W-1:0]      scan_reg, scan_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic                           dup_reg, dup_next;
    logic [pfd_pkg::OCC_W-1:0]      cnt_reg, cnt_next;
    logic                           res_added_reg, res_added_next;
    logic                           res_fwd_reg, res_fwd_next;
    pfd_pkg::packet_t               res_pkt_reg, res_pkt_next;
    pfd_pkg::cmd_t                  cmd_reg, cmd_next;
    pfd_pkg::in_item_t              item_reg, item_next;
    logic                           out_valid_reg, out_valid_next;
    pfd_pkg::out_item_t             out_reg, out_next;

    pfd_pkg::in_item_t              in_item;
    logic                           in_fire;
    logic                           rd_en, wr_en;
    logic [pfd_pkg::ADDR_W-1:0]     rd_addr, wr_addr;
    pfd_pkg::packet_t               rd_data, wr_data;
    logic [pfd_pkg::OCC_W-1:0]      limit_eff;
    logic [pfd_pkg::ADDR_W:0]       slot_sum;
    logic [pfd_pkg::ADDR_W-1:0]     scan_slot;
    logic                           evict;
    logic [pfd_pkg::ADDR_W-1:0]     base_idx;
    logic [pfd_pkg::OCC_W-1:0]      base_occ;
    logic [pfd_pkg::ADDR_W:0]       wr_sum;
    logic [pfd_pkg::ADDR_W-1:0]     oldest_inc;

    assign in_item       = pfd_pkg::in_item_t'(s_axis_tdata[pfd_pkg::IN_BITS-1:0]);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = pfd_pkg::M_DATA_W'(out_reg);

    always_comb begin
        if (limit_reg == '0) begin
            limit_eff = pfd_pkg::OCC_W'(1);
        end else if (32'(limit_reg) > 32'(pfd_pkg::DEPTH)) begin
            limit_eff = pfd_pkg::OCC_W'(pfd_pkg::DEPTH);
        end else begin
            limit_eff = pfd_pkg::OCC_W'(limit_reg);
        end
    end

    // oldest + offset, wrapped at the store depth
    assign slot_sum  = (pfd_pkg::ADDR_W + 1)'(oldest_reg) + (pfd_pkg::ADDR_W + 1)'(scan_reg);
    assign scan_slot = (32'(slot_sum) >= 32'(pfd_pkg::DEPTH))
                     ? pfd_pkg::ADDR_W'(32'(slot_sum) - 32'(pfd_pkg::DEPTH))
                     : pfd_pkg::ADDR_W'(slot_sum);

    assign oldest_inc = (32'(oldest_reg) == 32'(pfd_pkg::DEPTH - 1))
                      ? '0 : oldest_reg + pfd_pkg::ADDR_W'(1);

    assign evict    = (occ_reg >= limit_eff) && (occ_reg != '0);
    assign base_idx = evict ? oldest_inc : oldest_reg;
    assign base_occ = evict ? occ_reg - pfd_pkg::OCC_W'(1) : occ_reg;
    assign wr_sum   = (pfd_pkg::ADDR_W + 1)'(base_idx) + (pfd_pkg::ADDR_W + 1)'(base_occ);
    assign wr_addr  = (32'(wr_sum) >= 32'(pfd_pkg::DEPTH))
                    ? pfd_pkg::ADDR_W'(32'(wr_sum) - 32'(pfd_pkg::DEPTH))
                    : pfd_pkg::ADDR_W'(wr_sum);
    assign wr_data  = '{ts: item_reg.timestamp, dst: item_reg.destination,
                        src: item_reg.source};
    assign wr_en    = (state_reg == ST_COMMIT) && !dup_reg;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = oldest_reg;
        if (state_reg == ST_IDLE) begin
            rd_en = in_fire && (pfd_pkg::cmd_t'(s_axis_tuser[pfd_pkg::CMD_W-1:0])
                                == pfd_pkg::CMD_FORWARD) && (occ_reg != '0);
        end else if (state_reg == ST_SCAN) begin
            rd_en   = (scan_reg < occ_reg);
            rd_addr = scan_slot;
        end
    end

    pfd_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        occ_next       = occ_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        dup_next       = dup_reg;
        cnt_next       = cnt_reg;
        res_added_next = res_added_reg;
        res_fwd_next   = res_fwd_reg;
        res_pkt_next   = res_pkt_reg;
        cmd_next       = cmd_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_next       = out_reg;

        // compare of the entry read in the previous cycle
        if (cmp_valid_reg) begin
            if (rd_data.src == item_reg.source && rd_data.dst == item_reg.destination
                && rd_data.ts == item_reg.timestamp) begin
                dup_next = 1'b1;
            end
            if (rd_data.dst == item_reg.destination && rd_data.ts >= item_reg.start_time
                && rd_data.ts <= item_reg.end_time) begin
                cnt_next = cnt_reg + pfd_pkg::OCC_W'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd_next       = pfd_pkg::cmd_t'(s_axis_tuser[pfd_pkg::CMD_W-1:0]);
                    item_next      = in_item;
                    scan_next      = '0;
                    dup_next       = 1'b0;
                    cnt_next       = '0;
                    res_added_next = 1'b0;
                    res_fwd_next   = 1'b0;
                    res_pkt_next   = '0;
                    unique case (pfd_pkg::cmd_t'(s_axis_tuser[pfd_pkg::CMD_W-1:0]))
                        pfd_pkg::CMD_ADD,
                        pfd_pkg::CMD_COUNT:   state_next = ST_SCAN;
                        pfd_pkg::CMD_FORWARD: state_next = (occ_reg != '0) ? ST_FWD_DATA
                                                                           : ST_EMIT;
                        default:              state_next = ST_EMIT;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_reg < occ_reg) begin
                    scan_next      = scan_reg + pfd_pkg::OCC_W'(1);
                    cmp_valid_next = 1'b1;
                end else begin
                    state_next = (cmd_reg == pfd_pkg::CMD_ADD) ? ST_COMMIT : ST_EMIT;
                end
            end
            ST_FWD_DATA: begin
                res_fwd_next = 1'b1;
                res_pkt_next = rd_data;
                oldest_next  = oldest_inc;
                occ_next     = occ_reg - pfd_pkg::OCC_W'(1);
                state_next   = ST_EMIT;
            end
            ST_COMMIT: begin
                if (!dup_reg) begin
                    res_added_next = 1'b1;
                    oldest_next    = base_idx;
                    occ_next       = base_occ + pfd_pkg::OCC_W'(1);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next          = 1'b1;
                    out_next.added          = res_added_reg;
                    out_next.forward_valid  = res_fwd_reg;
                    out_next.out_source     = res_pkt_reg.src;
                    out_next.out_destination = res_pkt_reg.dst;
                    out_next.out_timestamp  = res_pkt_reg.ts;
                    out_next.match_count    = (cmd_reg == pfd_pkg::CMD_COUNT)
                                            ? pfd_pkg::CNT_W'(cnt_reg) : '0;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            limit_reg     <= pfd_pkg::LIMIT_RESET;
            oldest_reg    <= '0;
            occ_reg       <= '0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            occ_reg       <= occ_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
        dup_reg       <= dup_next;
        cnt_reg       <= cnt_next;
        res_added_reg <= res_added_next;
        res_fwd_reg   <= res_fwd_next;
        res_pkt_reg   <= res_pkt_next;
        cmd_reg       <= cmd_next;
        item_reg      <= item_next;
        out_reg       <= out_next;
    end

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(occ_reg) <= 32'(pfd_pkg::DEPTH))
        else $error("occupancy above depth");

    a_idle_no_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !cmp_valid_reg)
        else $error("compare pending while idle");

    a_fwd_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FWD_DATA) |=> (occ_reg == $past(occ_reg) - pfd_pkg::OCC_W'(1)))
        else $error("forward did not pop one packet");

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.added && out_reg.forward_valid))
        else $error("result marks both add and forward");

    a_write_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (32'(base_occ) < 32'(pfd_pkg::DEPTH)))
        else $error("write into full store");
`endif

endmodule

>>> rtl/pfd_ram.sv
// ----------------------------------------------------------------------------
// pfd_ram
// Packet store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfd_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [pfd_pkg::ADDR_W-1:0]    wr_addr,
    input  pfd_pkg::packet_t              wr_data,
    input  logic                          rd_en,
    input  logic [pfd_pkg::ADDR_W-1:0]    rd_addr,
    output pfd_pkg::packet_t              rd_data
);

    pfd_pkg::packet_t mem [pfd_pkg::DEPTH];
    pfd_pkg::packet_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/tb_packet_fifo_dedup_range_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_fifo_dedup_range_count
// Streams add, forward, count and unknown commands into the packet fifo and
// checks every result against a behavioral copy of the fifo kept in the bench.
// The fifo limit is changed between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_packet_fifo_dedup_range_count;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 135;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        pfd_pkg::cmd_t     cmd;
        pfd_pkg::in_item_t data;
    } fifo_req_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [pfd_pkg::LIMIT_W-1:0]    cfg_wr_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [pfd_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
    logic [pfd_pkg::S_USER_W-1:0]   s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [pfd_pkg::M_DATA_W-1:0]   m_axis_tdata;

    // stimulus and predicted results
    fifo_req_t                      pending_cmds[$];
    fifo_req_t                      cur_req;
    pfd_pkg::out_item_t             results_due[$];
    pfd_pkg::packet_t               recent_adds[$];
    int                             items_made = 0;
    logic [31:0]                    time_base;

    // packet fifo copy
    pfd_pkg::packet_t               pkt_store [pfd_pkg::DEPTH];
    int                             fifo_head = 0;
    int                             fifo_occ = 0;
    logic [pfd_pkg::LIMIT_W-1:0]    fifo_limit = pfd_pkg::LIMIT_RESET;

    int                             send_idle_pct = 14;
    int                             recv_idle_pct = 72;
    int                             mismatches = 0;
    int                             stall_cycles = 0;
    int                             recv_count = 0;
    int                             hold_left = 0;
    bit                             hold_done = 1'b0;
    pfd_pkg::out_item_t             got_result;
    logic [pfd_pkg::LIMIT_W-1:0]    phase_limit [PHASES] =
        '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd40, 7'd5, 7'd20, 7'd64, 7'd100, 7'd17};

    packet_fifo_dedup_range_count dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic pfd_pkg::out_item_t fifo_response(input fifo_req_t r);
        pfd_pkg::out_item_t o;
        bit                 dup;
        int                 lim;
        int                 n;
        pfd_pkg::packet_t   p;
        o = '0;
        case (r.cmd)
            pfd_pkg::CMD_ADD: begin
                dup = 1'b0;
                for (int k = 0; k < fifo_occ; k++) begin
                    p = pkt_store[(fifo_head + k) % pfd_pkg::DEPTH];
                    if (p.src == r.data.source && p.dst == r.data.destination &&
                        p.ts == r.data.timestamp)
                        dup = 1'b1;
                end
                if (!dup) begin
                    lim = (fifo_limit < 1) ? 1
                        : (fifo_limit > pfd_pkg::DEPTH) ? pfd_pkg::DEPTH : int'(fifo_limit);
                    if (fifo_occ >= lim && fifo_occ > 0) begin
                        fifo_head = (fifo_head + 1) % pfd_pkg::DEPTH;
                        fifo_occ--;
                    end
                    if (fifo_occ < pfd_pkg::DEPTH) begin
                        p.src = r.data.source;
                        p.dst = r.data.destination;
                        p.ts  = r.data.timestamp;
                        pkt_store[(fifo_head + fifo_occ) % pfd_pkg::DEPTH] = p;
                        fifo_occ++;
                    end
                    o.added = 1'b1;
                end
            end
            pfd_pkg::CMD_FORWARD: begin
                if (fifo_occ > 0) begin
                    p = pkt_store[fifo_head];
                    fifo_head = (fifo_head + 1) % pfd_pkg::DEPTH;
                    fifo_occ--;
                    o.forward_valid   = 1'b1;
                    o.out_source      = p.src;
                    o.out_destination = p.dst;
                    o.out_timestamp   = p.ts;
                end
            end
            pfd_pkg::CMD_COUNT: begin
                n = 0;
                for (int k = 0; k < fifo_occ; k++) begin
                    p = pkt_store[(fifo_head + k) % pfd_pkg::DEPTH];
                    if (p.dst == r.data.destination && p.ts >= r.data.start_time &&
                        p.ts <= r.data.end_time)
                        n++;
                end
                o.match_count = n[pfd_pkg::CNT_W-1:0];
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic queue_req(input pfd_pkg::cmd_t c, input logic [15:0] src,
                             input logic [15:0] dst, input logic [31:0] ts,
                             input logic [31:0] lo, input logic [31:0] hi);
        fifo_req_t        r;
        pfd_pkg::packet_t p;
        r.cmd              = c;
        r.data.source      = src;
        r.data.destination = dst;
        r.data.timestamp   = ts;
        r.data.start_time  = lo;
        r.data.end_time    = hi;
        pending_cmds = {pending_cmds, r};
        items_made++;
        if (c == pfd_pkg::CMD_ADD) begin
            p.src = src;
            p.dst = dst;
            p.ts  = ts;
            recent_adds = {recent_adds, p};
            if (recent_adds.size() > 8)
                void'(recent_adds.pop_front());
        end
    endtask

    function automatic logic [15:0] pick_node();
        case ($urandom_range(0, 9))
            6:       return 16'h0000;
            7:       return 16'hffff;
            8, 9:    return 16'($urandom);
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 9))
            8:       return $urandom;
            9:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
            default: begin
                time_base = time_base + $urandom_range(0, 2);
                return time_base;
            end
        endcase
    endfunction

    task automatic gen_add();
        pfd_pkg::packet_t p;
        if (recent_adds.size() > 0 && $urandom_range(0, 5) == 0) begin
            p = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
            queue_req(pfd_pkg::CMD_ADD, p.src, p.dst, p.ts, $urandom, $urandom);
        end else begin
            queue_req(pfd_pkg::CMD_ADD, pick_node(), pick_node(), pick_time(),
                      $urandom, $urandom);
        end
    endtask

    task automatic gen_count();
        logic [31:0] lo;
        logic [31:0] hi;
        case ($urandom_range(0, 4))
            0: begin
                lo = 32'h0;
                hi = 32'hffff_ffff;
            end
            1: begin
                lo = $urandom_range(32'hffff_ffff, 1);
                hi = $urandom_range(lo - 1, 0);
            end
            2: begin
                lo = time_base;
                hi = time_base;
            end
            default: begin
                lo = time_base - $urandom_range(0, 40);
                hi = time_base + $urandom_range(0, 5);
            end
        endcase
        queue_req(pfd_pkg::CMD_COUNT, 16'($urandom), pick_node(), $urandom, lo, hi);
    endtask

    // run of adds to one destination, closed by a count over the run
    task automatic add_run(input int k);
        logic [15:0] d;
        logic [31:0] t0;
        d  = pick_node();
        t0 = time_base + 1;
        for (int i = 0; i < k; i++) begin
            time_base = time_base + 1;
            queue_req(pfd_pkg::CMD_ADD, pick_node(), d, time_base, $urandom, $urandom);
        end
        queue_req(pfd_pkg::CMD_COUNT, 16'($urandom), d, $urandom, t0 - $urandom_range(0, 1),
                  time_base + $urandom_range(0, 1));
    endtask

    task automatic gen_sequence();
        int               r;
        pfd_pkg::packet_t p;
        case ($urandom_range(0, 9))
            6, 7: add_run($urandom_range(0, 3) == 0 ? $urandom_range(60, 70)
                                                    : $urandom_range(4, 20));
            8: begin
                r = $urandom_range(2, 12);
                for (int i = 0; i < r; i++)
                    queue_req(pfd_pkg::CMD_FORWARD, 16'($urandom), 16'($urandom),
                              $urandom, $urandom, $urandom);
            end
            9: begin
                gen_add();
                p = recent_adds[$];
                queue_req(pfd_pkg::CMD_ADD, p.src, p.dst, p.ts, $urandom, $urandom);
                queue_req(pfd_pkg::CMD_COUNT, 16'($urandom), p.dst, $urandom, p.ts, p.ts);
                queue_req(pfd_pkg::CMD_ADD, p.src, p.dst, p.ts, $urandom, $urandom);
            end
            default: begin
                r = $urandom_range(0, 19);
                if (r < 10)
                    gen_add();
                else if (r < 14)
                    queue_req(pfd_pkg::CMD_FORWARD, 16'($urandom), 16'($urandom),
                              $urandom, $urandom, $urandom);
                else if (r < 19)
                    gen_count();
                else
                    queue_req(pfd_pkg::CMD_NONE, 16'($urandom), 16'($urandom),
                              $urandom, $urandom, $urandom);
            end
        endcase
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_limit(input logic [pfd_pkg::LIMIT_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        fifo_limit = v;
    endtask

    task automatic report_mismatch(input string what, input pfd_pkg::out_item_t w,
                                   input pfd_pkg::out_item_t g);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("  want added=%0b fwd=%0b src=%h dst=%h ts=%h cnt=%0d",
                     w.added, w.forward_valid, w.out_source, w.out_destination,
                     w.out_timestamp, w.match_count);
            $display("  got  added=%0b fwd=%0b src=%h dst=%h ts=%h cnt=%0d",
                     g.added, g.forward_valid, g.out_source, g.out_destination,
                     g.out_timestamp, g.match_count);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                results_due = {results_due, fifo_response(cur_req)};
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_req = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_req.data;
                    s_axis_tuser  <= {{(pfd_pkg::S_USER_W - pfd_pkg::CMD_W){1'b0}},
                                      cur_req.cmd};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                recv_count++;
            if (!hold_done && recv_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_result = pfd_pkg::out_item_t'(m_axis_tdata[pfd_pkg::OUT_BITS-1:0]);
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing awaited", '0, got_result);
            end else if (got_result.added !== results_due[0].added ||
                         got_result.forward_valid !== results_due[0].forward_valid ||
                         got_result.out_source !== results_due[0].out_source ||
                         got_result.out_destination !== results_due[0].out_destination ||
                         got_result.out_timestamp !== results_due[0].out_timestamp ||
                         got_result.match_count !== results_due[0].match_count) begin
                report_mismatch("result mismatch", results_due.pop_front(), got_result);
            end else begin
                void'(results_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int target;
        time_base = $urandom;
        phase_limit[8] = pfd_pkg::LIMIT_W'($urandom_range(3, 63));
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at the reset limit
        queue_req(pfd_pkg::CMD_FORWARD, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff);
        queue_req(pfd_pkg::CMD_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'hffff_ffff);
        queue_req(pfd_pkg::CMD_ADD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_ADD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_ADD, 16'hffff, 16'hffff, 32'hffff_ffff, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_ADD, 16'hffff, 16'h0, 32'hffff_ffff, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_ADD, 16'h0, 16'hffff, 32'h0, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_ADD, 16'h0, 16'h0, 32'h1, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_ADD, 16'h1, 16'h2, 32'h5, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'hffff_ffff);
        queue_req(pfd_pkg::CMD_COUNT, 16'h0, 16'h0, 32'h0, 32'h1, 32'h1);
        queue_req(pfd_pkg::CMD_COUNT, 16'h0, 16'h0, 32'h0, 32'h5, 32'h2);
        queue_req(pfd_pkg::CMD_COUNT, 16'h0, 16'hffff, 32'h0, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_COUNT, 16'h0, 16'hffff, 32'h0, 32'hffff_ffff, 32'hffff_ffff);
        queue_req(pfd_pkg::CMD_NONE, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff);
        queue_req(pfd_pkg::CMD_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
        queue_req(pfd_pkg::CMD_ADD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++)
            queue_req(pfd_pkg::CMD_FORWARD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            repeat (4) @(posedge aclk);
            if (p == 4) begin
                send_idle_pct = 72;
                recv_idle_pct = 14;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_limit(phase_limit[p]);
            target = items_made + PHASE_ITEMS;
            while (items_made < target)
                gen_sequence();
            add_run($urandom_range(10, 30));
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (results_due.size() != 0) begin
            $display("%0d results never arrived", results_due.size());
            mismatches += results_due.size();
        end
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
